[rtl/core/wsr_pkg.sv]
// Shared types and constants for the windowed-sinc resampler.
// Used by the divider and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wsr_pkg;

    // Divider operand widths
    localparam int DVD_W = 64;
    localparam int DVS_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd1;

    localparam logic [3:0]  HALF_WIDTH_RST = 4'd4;
    localparam logic [10:0] ROW_LENGTH_RST = 11'd1024;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Fixed-point constants (Q30)
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] SC1     = 31'd1686629713;
    localparam logic [30:0] SC3     = 31'd693598669;
    localparam logic [30:0] SC5     = 31'd85569306;
    localparam logic [30:0] SC7     = 31'd5026995;
    localparam logic [30:0] SC9     = 31'd172272;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] position;
        logic signed [23:0] sample_re;
        logic signed [23:0] sample_im;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_re;
        logic signed [31:0] out_im;
        logic               out_of_range;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    // Horner coefficients after the innermost one, outermost last
    function automatic logic [30:0] horner_coef(input logic [1:0] step);
        logic [30:0] c;
        case (step)
            2'd0:    c = SC7;
            2'd1:    c = SC5;
            2'd2:    c = SC3;
            default: c = SC1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/wsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/wsr_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on wsr_pkg for operand widths and request/response types.
`timescale 1ns / 1ps
`default_nettype none

module wsr_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wsr_pkg::div_req_t req,
    output wsr_pkg::div_rsp_t      rsp
);

    localparam int DVD_W = wsr_pkg::DVD_W;
    localparam int DVS_W = wsr_pkg::DVS_W;
    localparam int CW    = $clog2(DVD_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   shifted;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dvs_next = req.divisor;
            quo_next = req.dividend;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = CW'(cnt_reg + 1'b1);
            if (cnt_reg == CW'(DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/core/windowed_sinc_resampler.sv]
// Windowed-sinc (Lanczos) resampler over one row on a nonuniform grid.
// Depends on wsr_pkg, wsr_ram and wsr_div.
`timescale 1ns / 1ps
`default_nettype none

// A beat is taken when start is high and busy is low. A load beat writes the
// row store in that same cycle and busy stays low, so loads stream at one per
// cycle. A query raises busy until its result is shown: result_valid is high
// for exactly one cycle and the result must be taken then, as there is no way
// to stall it. An in-range query runs a linear grid search for the index x0
// (one row-store read per cycle), then visits the window taps that fall inside
// the row (at most 2 * half_width + 1); each tap makes at most four passes
// through the shared divider. The row store needs no clearing pass after reset.
module windowed_sinc_resampler #(
    parameter int ROW_DEPTH      = 1024,
    parameter int MAX_HALF_WIDTH = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire wsr_pkg::item_t                   item,
    output logic                                  result_valid,
    output wsr_pkg::result_t                      result,
    input  wire logic                             wr_en,
    input  wire logic [wsr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [wsr_pkg::CFG_DATA_W-1:0]   wr_data
);

    localparam int AW = $clog2(ROW_DEPTH);
    localparam int LW = $clog2(ROW_DEPTH + 1);
    localparam int HW = $clog2(MAX_HALF_WIDTH + 1);
    localparam int IW = ((AW > HW) ? AW : HW) + 2;
    localparam int UW = HW + 16;

    typedef enum logic [22:0] {
        ST_IDLE      = 23'd1 << 0,
        ST_CHK_LO    = 23'd1 << 1,
        ST_CHK_HI    = 23'd1 << 2,
        ST_SEARCH    = 23'd1 << 3,
        ST_TAP_START = 23'd1 << 4,
        ST_TAP_RD0   = 23'd1 << 5,
        ST_TAP_RD1   = 23'd1 << 6,
        ST_DIV_U     = 23'd1 << 7,
        ST_DIV_UA    = 23'd1 << 8,
        ST_SIN_SQ    = 23'd1 << 9,
        ST_SIN_H0    = 23'd1 << 10,
        ST_SIN_HORN  = 23'd1 << 11,
        ST_SIN_END   = 23'd1 << 12,
        ST_PU_MUL    = 23'd1 << 13,
        ST_PU_GET    = 23'd1 << 14,
        ST_DIV_R1    = 23'd1 << 15,
        ST_DIV_R2    = 23'd1 << 16,
        ST_W_GET     = 23'd1 << 17,
        ST_MAC_RE    = 23'd1 << 18,
        ST_MAC_IM    = 23'd1 << 19,
        ST_MAC_ACC   = 23'd1 << 20,
        ST_TAP_NEXT  = 23'd1 << 21,
        ST_FINISH    = 23'd1 << 22
    } state_t;

    // Quarter-wave argument in Q30 for a phase in Q.16 half-turns
    function automatic logic [30:0] sin_x(input logic [31:0] v);
        logic [15:0] r;
        r = v[15:0];
        if (r > 16'h8000)
        begin
            r = 16'(17'h10000 - {1'b0, r});
        end
        return {r, 15'h0};
    endfunction

    // Cap a quotient at one in Q30
    function automatic logic [30:0] cap_one(input logic [63:0] v);
        return (v > 64'(wsr_pkg::ONE_Q30)) ? wsr_pkg::ONE_Q30 : v[30:0];
    endfunction

    // Round half up by 2^30 and saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc);
        logic signed [63:0] n;
        logic signed [63:0] r;
        n = acc + 64'sd536870912;
        r = n >>> 30;
        if (r > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (r < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r[31:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [3:0]              half_width_reg, half_width_next;
    logic [10:0]             row_length_reg, row_length_next;
    logic [AW-1:0]           load_index_reg, load_index_next;

    logic signed [31:0]      q_reg, q_next;
    logic [HW-1:0]           a_reg, a_next;
    logic [LW-1:0]           len_reg, len_next;
    logic                    lo_fail_reg, lo_fail_next;
    logic [AW-1:0]           x0_reg, x0_next;
    logic signed [HW:0]      k_reg, k_next;
    logic signed [IW-1:0]    idx_reg, idx_next;
    logic signed [31:0]      ga_reg, ga_next;
    logic signed [23:0]      smp_re_reg, smp_re_next;
    logic signed [23:0]      smp_im_reg, smp_im_next;
    logic [UW-1:0]           u_reg, u_next;
    logic [30:0]             x_reg, x_next;
    logic [30:0]             x2_reg, x2_next;
    logic                    sneg_reg, sneg_next;
    logic                    pass_reg, pass_next;
    logic [1:0]              h_reg, h_next;
    logic [30:0]             s1_reg, s1_next;
    logic [30:0]             s2_reg, s2_next;
    logic                    n2_reg, n2_next;
    logic [39:0]             pu_reg, pu_next;
    logic [30:0]             w_reg, w_next;
    logic signed [63:0]      acc_re_reg, acc_re_next;
    logic signed [63:0]      acc_im_reg, acc_im_next;
    logic signed [65:0]      prod_reg, prod_next;
    wsr_pkg::result_t        result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic                    accept;
    logic                    load_we;
    logic [3:0]              a_c;
    logic [LW-1:0]           len_c;
    logic [AW-1:0]           grid_raddr;
    logic [AW-1:0]           last_addr;
    logic signed [31:0]      grid_rdata;
    logic signed [23:0]      re_rdata;
    logic signed [23:0]      im_rdata;
    logic signed [IW-1:0]    idx_c;
    logic signed [IW-1:0]    last_idx;
    logic [AW-1:0]           addr_a_c;
    logic [AW-1:0]           addr_a_reg;
    logic signed [32:0]      d_c;
    logic signed [32:0]      num_c;
    logic [32:0]             mn_c;
    logic [32:0]             md_c;
    logic signed [31:0]      gi_c;
    logic [31:0]             pn_c;
    logic [30:0]             s_c;
    logic signed [32:0]      sw_c;
    logic                    mul_en;
    logic signed [32:0]      mul_a;
    logic signed [32:0]      mul_b;
    wsr_pkg::div_req_t       div_req;
    wsr_pkg::div_rsp_t       div_rsp;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign load_we = accept && (item.cmd == wsr_pkg::CMD_LOAD);

    // Clamp the configuration to its legal range
    always_comb
    begin
        if (half_width_reg == 4'd0)
        begin
            a_c = 4'd1;
        end
        else if (32'(half_width_reg) > MAX_HALF_WIDTH)
        begin
            a_c = 4'(MAX_HALF_WIDTH);
        end
        else
        begin
            a_c = half_width_reg;
        end
        if (row_length_reg < 11'd2)
        begin
            len_c = LW'(2);
        end
        else if (32'(row_length_reg) > ROW_DEPTH)
        begin
            len_c = LW'(ROW_DEPTH);
        end
        else
        begin
            len_c = LW'(row_length_reg);
        end
    end

    // Tap index and the two grid addresses that set its spacing
    assign idx_c      = $signed({{(IW-AW){1'b0}}, x0_reg}) + {{(IW-HW-1){k_reg[HW]}}, k_reg};
    assign last_idx   = $signed({{(IW-LW){1'b0}}, len_reg}) - IW'(1);
    assign last_addr  = AW'(len_reg - 1'b1);
    assign addr_a_c   = (idx_c == 0) ? AW'(1) : idx_c[AW-1:0];
    assign addr_a_reg = (idx_reg == 0) ? AW'(1) : idx_reg[AW-1:0];

    assign gi_c  = (idx_reg == 0) ? grid_rdata : ga_reg;
    assign d_c   = 33'(ga_reg) - 33'(grid_rdata);
    assign num_c = 33'(q_reg) - 33'(gi_c);
    assign mn_c  = num_c[32] ? 33'(-num_c) : 33'(num_c);
    assign md_c  = d_c[32] ? 33'(-d_c) : 33'(d_c);

    assign pn_c = {1'b0, wsr_pkg::horner_coef(h_reg)} - prod_reg[61:30];
    assign s_c  = (prod_reg[61:30] > 32'(wsr_pkg::ONE_Q30)) ? wsr_pkg::ONE_Q30
                                                            : prod_reg[60:30];
    assign sw_c = n2_reg ? -$signed({2'b0, w_reg}) : $signed({2'b0, w_reg});

    // Grid read address per step
    always_comb
    begin
        case (state_reg)
            ST_CHK_LO:    grid_raddr = last_addr;
            ST_SEARCH:    grid_raddr = AW'(x0_reg + 1'b1);
            ST_TAP_START: grid_raddr = addr_a_c;
            ST_TAP_RD0:   grid_raddr = AW'(addr_a_reg - 1'b1);
            default:      grid_raddr = '0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        half_width_next   = half_width_reg;
        row_length_next   = row_length_reg;
        load_index_next   = load_index_reg;
        q_next            = q_reg;
        a_next            = a_reg;
        len_next          = len_reg;
        lo_fail_next      = lo_fail_reg;
        x0_next           = x0_reg;
        k_next            = k_reg;
        idx_next          = idx_reg;
        ga_next           = ga_reg;
        smp_re_next       = smp_re_reg;
        smp_im_next       = smp_im_reg;
        u_next            = u_reg;
        x_next            = x_reg;
        x2_next           = x2_reg;
        sneg_next         = sneg_reg;
        pass_next         = pass_reg;
        h_next            = h_reg;
        s1_next           = s1_reg;
        s2_next           = s2_reg;
        n2_next           = n2_reg;
        pu_next           = pu_reg;
        w_next            = w_reg;
        acc_re_next       = acc_re_reg;
        acc_im_next       = acc_im_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mul_en            = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        div_req.start     = 1'b0;
        div_req.dividend  = '0;
        div_req.divisor   = '0;

        // Configuration writes; unknown indexes drop
        if (wr_en)
        begin
            if (wr_index == wsr_pkg::REG_HALF_WIDTH)
            begin
                half_width_next = wr_data[3:0];
            end
            else if (wr_index == wsr_pkg::REG_ROW_LENGTH)
            begin
                row_length_next = wr_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (load_we)
                begin
                    if (32'(load_index_reg) + 1 >= 32'(len_c))
                    begin
                        load_index_next = '0;
                    end
                    else
                    begin
                        load_index_next = AW'(load_index_reg + 1'b1);
                    end
                end
                else if (accept)
                begin
                    q_next      = item.position;
                    a_next      = HW'(a_c);
                    len_next    = len_c;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    state_next  = ST_CHK_LO;
                end
            end
            ST_CHK_LO:
            begin
                lo_fail_next = (q_reg < grid_rdata);
                state_next   = ST_CHK_HI;
            end
            ST_CHK_HI:
            begin
                if (lo_fail_reg || (q_reg > grid_rdata))
                begin
                    result_next.out_re       = '0;
                    result_next.out_im       = '0;
                    result_next.out_of_range = 1'b1;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    x0_next    = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // Advance to the first sample at or above the query
                if ((grid_rdata < q_reg) && (x0_reg != last_addr))
                begin
                    x0_next = AW'(x0_reg + 1'b1);
                end
                else
                begin
                    k_next     = -$signed({1'b0, a_reg});
                    state_next = ST_TAP_START;
                end
            end
            ST_TAP_START:
            begin
                idx_next = idx_c;
                if (idx_c > last_idx)
                begin
                    state_next = ST_FINISH;
                end
                else if (idx_c < 0)
                begin
                    state_next = ST_TAP_NEXT;
                end
                else
                begin
                    state_next = ST_TAP_RD0;
                end
            end
            ST_TAP_RD0:
            begin
                ga_next     = grid_rdata;
                smp_re_next = re_rdata;
                smp_im_next = im_rdata;
                state_next  = ST_TAP_RD1;
            end
            ST_TAP_RD1:
            begin
                // Drop taps with zero spacing, else start the offset divide
                if (d_c == 0)
                begin
                    state_next = ST_TAP_NEXT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'({mn_c, 16'h0});
                    div_req.divisor  = 40'(md_c);
                    state_next       = ST_DIV_U;
                end
            end
            ST_DIV_U:
            begin
                if (div_rsp.done)
                begin
                    u_next = div_rsp.quotient[UW-1:0];
                    if (div_rsp.quotient >= 64'({a_reg, 16'h0}))
                    begin
                        state_next = ST_TAP_NEXT;
                    end
                    else if (div_rsp.quotient == 64'd0)
                    begin
                        w_next     = wsr_pkg::ONE_Q30;
                        n2_next    = 1'b0;
                        state_next = ST_MAC_RE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = 64'(div_rsp.quotient[UW-1:0]);
                        div_req.divisor  = 40'(a_reg);
                        state_next       = ST_DIV_UA;
                    end
                end
            end
            ST_DIV_UA:
            begin
                if (div_rsp.done)
                begin
                    x_next     = sin_x(div_rsp.quotient[31:0]);
                    sneg_next  = div_rsp.quotient[16];
                    pass_next  = 1'b0;
                    state_next = ST_SIN_SQ;
                end
            end
            ST_SIN_SQ:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({2'b0, x_reg});
                mul_b      = $signed({2'b0, x_reg});
                state_next = ST_SIN_H0;
            end
            ST_SIN_H0:
            begin
                x2_next    = prod_reg[60:30];
                h_next     = 2'd0;
                mul_en     = 1'b1;
                mul_a      = $signed({2'b0, prod_reg[60:30]});
                mul_b      = $signed({2'b0, wsr_pkg::SC9});
                state_next = ST_SIN_HORN;
            end
            ST_SIN_HORN:
            begin
                // One Horner step, then the final multiply by x
                mul_en = 1'b1;
                mul_b  = $signed({1'b0, pn_c});
                if (h_reg != 2'd3)
                begin
                    mul_a  = $signed({2'b0, x2_reg});
                    h_next = 2'(h_reg + 1'b1);
                end
                else
                begin
                    mul_a      = $signed({2'b0, x_reg});
                    state_next = ST_SIN_END;
                end
            end
            ST_SIN_END:
            begin
                if (!pass_reg)
                begin
                    s1_next    = s_c;
                    x_next     = sin_x(32'(u_reg));
                    sneg_next  = u_reg[16];
                    pass_next  = 1'b1;
                    state_next = ST_SIN_SQ;
                end
                else
                begin
                    s2_next    = s_c;
                    n2_next    = sneg_reg && (s_c != 31'd0);
                    state_next = ST_PU_MUL;
                end
            end
            ST_PU_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, wsr_pkg::PI_Q30});
                mul_b      = $signed(33'(u_reg));
                state_next = ST_PU_GET;
            end
            ST_PU_GET:
            begin
                pu_next          = prod_reg[55:16];
                div_req.start    = 1'b1;
                div_req.dividend = 64'({s1_reg, 30'h0});
                div_req.divisor  = prod_reg[55:16];
                state_next       = ST_DIV_R1;
            end
            ST_DIV_R1:
            begin
                if (div_rsp.done)
                begin
                    mul_en           = 1'b1;
                    mul_a            = $signed(33'(a_reg));
                    mul_b            = $signed({2'b0, cap_one(div_rsp.quotient)});
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'({s2_reg, 30'h0});
                    div_req.divisor  = pu_reg;
                    state_next       = ST_DIV_R2;
                end
            end
            ST_DIV_R2:
            begin
                if (div_rsp.done)
                begin
                    mul_en     = 1'b1;
                    mul_a      = $signed({2'b0, cap_one(64'(prod_reg[35:0]))});
                    mul_b      = $signed({2'b0, cap_one(div_rsp.quotient)});
                    state_next = ST_W_GET;
                end
            end
            ST_W_GET:
            begin
                w_next     = prod_reg[60:30];
                state_next = ST_MAC_RE;
            end
            ST_MAC_RE:
            begin
                mul_en     = 1'b1;
                mul_a      = 33'(smp_re_reg);
                mul_b      = sw_c;
                state_next = ST_MAC_IM;
            end
            ST_MAC_IM:
            begin
                acc_re_next = acc_re_reg + prod_reg[63:0];
                mul_en      = 1'b1;
                mul_a       = 33'(smp_im_reg);
                mul_b       = sw_c;
                state_next  = ST_MAC_ACC;
            end
            ST_MAC_ACC:
            begin
                acc_im_next = acc_im_reg + prod_reg[63:0];
                state_next  = ST_TAP_NEXT;
            end
            ST_TAP_NEXT:
            begin
                if (k_reg == $signed({1'b0, a_reg}))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_TAP_START;
                end
            end
            ST_FINISH:
            begin
                result_next.out_re       = round_sat(acc_re_reg);
                result_next.out_im       = round_sat(acc_im_reg);
                result_next.out_of_range = 1'b0;
                result_valid_next        = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shared multiplier with a result register
    assign prod_next = mul_en ? (mul_a * mul_b) : prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            half_width_reg   <= wsr_pkg::HALF_WIDTH_RST;
            row_length_reg   <= wsr_pkg::ROW_LENGTH_RST;
            load_index_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            half_width_reg   <= half_width_next;
            row_length_reg   <= row_length_next;
            load_index_reg   <= load_index_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        a_reg       <= a_next;
        len_reg     <= len_next;
        lo_fail_reg <= lo_fail_next;
        x0_reg      <= x0_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        ga_reg      <= ga_next;
        smp_re_reg  <= smp_re_next;
        smp_im_reg  <= smp_im_next;
        u_reg       <= u_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        sneg_reg    <= sneg_next;
        pass_reg    <= pass_next;
        h_reg       <= h_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        n2_reg      <= n2_next;
        pu_reg      <= pu_next;
        w_reg       <= w_next;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
        prod_reg    <= prod_next;
        result_reg  <= result_next;
    end

    // Row store
    wsr_ram #(
        .WIDTH (32),
        .DEPTH (ROW_DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_index_reg),
        .wdata (item.position),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    wsr_ram #(
        .WIDTH (24),
        .DEPTH (ROW_DEPTH)
    ) u_re_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_index_reg),
        .wdata (item.sample_re),
        .raddr (idx_c[AW-1:0]),
        .rdata (re_rdata)
    );

    wsr_ram #(
        .WIDTH (24),
        .DEPTH (ROW_DEPTH)
    ) u_im_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_index_reg),
        .wdata (item.sample_im),
        .raddr (idx_c[AW-1:0]),
        .rdata (im_rdata)
    );

    wsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire
